/* rtl/bbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// types, codes and helpers shared by the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int BBC_STACK_DEPTH = 64;
    localparam int BBC_QUEUE_DEPTH = 2;
    localparam int BBC_LINE_W      = 24;

    localparam logic [2:0] ST_BALANCED = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_UNCLOSED = 3'd2;
    localparam logic [2:0] ST_STRAY    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_OPEN    = 3'd1;
    localparam logic [2:0] KIND_CLOSE   = 3'd2;
    localparam logic [2:0] KIND_NEWLINE = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    localparam logic [2:0] CODE_BRACE_L = 3'd0;
    localparam logic [2:0] CODE_BRACK_L = 3'd1;
    localparam logic [2:0] CODE_PAREN_L = 3'd2;
    localparam logic [2:0] CODE_BRACE_R = 3'd3;
    localparam logic [2:0] CODE_BRACK_R = 3'd4;
    localparam logic [2:0] CODE_PAREN_R = 3'd5;
    localparam logic [2:0] CODE_CLOSE_OFS = 3'd3;

    localparam logic [7:0] CH_BRACE_L = 8'h7B;
    localparam logic [7:0] CH_BRACK_L = 8'h5B;
    localparam logic [7:0] CH_PAREN_L = 8'h28;
    localparam logic [7:0] CH_BRACE_R = 8'h7D;
    localparam logic [7:0] CH_BRACK_R = 8'h5D;
    localparam logic [7:0] CH_PAREN_R = 8'h29;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic [2:0]            status;
        logic [BBC_LINE_W-1:0] line_number;
        logic [7:0]            found_char;
        logic [7:0]            top_char;
    } t_result;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] code;
        logic [7:0] char_code;
    } t_op;

    function automatic logic [7:0] bbc_code_ascii(input logic [2:0] code);
        logic [7:0] ch;
        case (code)
            CODE_BRACE_L: ch = CH_BRACE_L;
            CODE_BRACK_L: ch = CH_BRACK_L;
            CODE_PAREN_L: ch = CH_PAREN_L;
            CODE_BRACE_R: ch = CH_BRACE_R;
            CODE_BRACK_R: ch = CH_BRACK_R;
            CODE_PAREN_R: ch = CH_PAREN_R;
            default:      ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

/* rtl/bbc_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_fifo
// small register queue, push/full on the write side, pop/empty on the read side
// ----------------------------------------------------------------------------
module bbc_fifo
    import bbc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = BBC_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/bbc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_front
// accepts bytes, classifies them into stack operations, drops plain text
// ----------------------------------------------------------------------------
module bbc_front
    import bbc_pkg::*;
(
    input  wire t_item  i_item,
    input  wire logic   i_push,
    output logic        o_full,
    output logic        o_op_push,
    output t_op         o_op,
    input  wire logic   i_op_full
);

    assign o_full = i_op_full;

    always_comb begin
        o_op.char_code = i_item.char_code;
        o_op.code      = CODE_BRACE_L;
        o_op.kind      = KIND_NONE;
        if (i_item.end_of_text) begin
            o_op.kind = KIND_END;
        end else begin
            case (i_item.char_code)
                CH_BRACE_L: begin
                    o_op.kind = KIND_OPEN;
                    o_op.code = CODE_BRACE_L;
                end
                CH_BRACK_L: begin
                    o_op.kind = KIND_OPEN;
                    o_op.code = CODE_BRACK_L;
                end
                CH_PAREN_L: begin
                    o_op.kind = KIND_OPEN;
                    o_op.code = CODE_PAREN_L;
                end
                CH_BRACE_R: begin
                    o_op.kind = KIND_CLOSE;
                    o_op.code = CODE_BRACE_R;
                end
                CH_BRACK_R: begin
                    o_op.kind = KIND_CLOSE;
                    o_op.code = CODE_BRACK_R;
                end
                CH_PAREN_R: begin
                    o_op.kind = KIND_CLOSE;
                    o_op.code = CODE_PAREN_R;
                end
                CH_NEWLINE: begin
                    o_op.kind = KIND_NEWLINE;
                end
                default: begin
                    o_op.kind = KIND_NONE;
                end
            endcase
        end
    end

    // plain text bytes change nothing downstream
    assign o_op_push = i_push && !i_op_full && (o_op.kind != KIND_NONE);

endmodule
`default_nettype wire

/* rtl/bbc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_back
// executes stack operations: top register, stack memory with prefetched
// second entry, line counter, halt flag and result generation
// ----------------------------------------------------------------------------
module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = BBC_STACK_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_op_empty,
    input  wire t_op   i_op,
    output logic       o_op_pop,
    input  wire logic  i_res_full,
    output logic       o_res_push,
    output t_result    o_res
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    logic [2:0]            r_stack [STACK_DEPTH];
    logic [LVL_W-1:0]      r_level, n_level;
    logic [2:0]            r_top, n_top;
    logic [BBC_LINE_W-1:0] r_line, n_line;
    logic                  r_halted, n_halted;
    logic [2:0]            r_rd;
    logic                  r_byp;
    logic [2:0]            r_byp_code;
    logic [2:0]            second;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [AW-1:0]         rd_addr;
    logic                  push_req;
    logic [2:0]            push_code;
    logic                  stack_nz;

    assign o_op_pop = !i_op_empty && !i_res_full;
    assign second   = r_byp ? r_byp_code : r_rd;
    assign stack_nz = (r_level != '0);
    assign wa       = AW'(r_level - LVL_W'(1));

    always_comb begin
        n_level    = r_level;
        n_top      = r_top;
        n_line     = r_line;
        n_halted   = r_halted;
        we         = 1'b0;
        push_req   = 1'b0;
        push_code  = i_op.code;
        o_res_push = 1'b0;
        o_res.status      = ST_BALANCED;
        o_res.line_number = r_line;
        o_res.found_char  = 8'h00;
        o_res.top_char    = stack_nz ? bbc_code_ascii(r_top) : 8'h00;
        if (o_op_pop) begin
            case (i_op.kind)
                KIND_END: begin
                    if (!r_halted) begin
                        o_res_push = 1'b1;
                        if (!stack_nz) begin
                            o_res.status = ST_BALANCED;
                        end else if (r_top <= CODE_PAREN_L) begin
                            o_res.status = ST_UNCLOSED;
                        end else begin
                            o_res.status = ST_STRAY;
                        end
                    end
                    n_level  = '0;
                    n_line   = BBC_LINE_W'(1);
                    n_halted = 1'b0;
                end
                KIND_OPEN: begin
                    push_req = !r_halted;
                end
                KIND_CLOSE: begin
                    if (!r_halted) begin
                        if (stack_nz && (r_top == (i_op.code - CODE_CLOSE_OFS))) begin
                            n_level = r_level - LVL_W'(1);
                            n_top   = second;
                        end else if (stack_nz) begin
                            o_res_push       = 1'b1;
                            o_res.status     = ST_MISMATCH;
                            o_res.found_char = i_op.char_code;
                            n_halted         = 1'b1;
                        end else begin
                            push_req = 1'b1;
                        end
                    end
                end
                KIND_NEWLINE: begin
                    if (!r_halted && (r_line != '1)) begin
                        n_line = r_line + BBC_LINE_W'(1);
                    end
                end
                default: begin
                    n_level = r_level;
                end
            endcase
        end
        if (push_req) begin
            if (r_level == LVL_W'(STACK_DEPTH)) begin
                o_res_push   = 1'b1;
                o_res.status = ST_OVERFLOW;
                n_halted     = 1'b1;
            end else begin
                we      = stack_nz;
                n_top   = push_code;
                n_level = r_level + LVL_W'(1);
            end
        end
    end

    // prefetch the entry below the next top
    assign rd_addr = (n_level >= LVL_W'(2)) ? AW'(n_level - LVL_W'(2)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_line   <= BBC_LINE_W'(1);
            r_halted <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            r_level  <= n_level;
            r_line   <= n_line;
            r_halted <= n_halted;
            r_byp    <= we && (wa == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_byp_code <= r_top;
        if (we) begin
            r_stack[wa] <= r_top;
        end
        r_rd <= r_stack[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/bracket_balance_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_balance_checker
// bracket balance checker over a byte stream with line tracking
// ----------------------------------------------------------------------------
// input channel: push/full, one byte (or end marker) per transaction in i_data.
// result channel: empty/pop, o_data holds status, line number, offending
// closer and top of stack; a transaction only comes from a mismatch, an
// overflow or an end marker while not halted.
// result path: the front classifier writes a 2-entry op queue, the back
// executor pops it and writes a 2-entry result queue, whose empty goes low
// once a result is written into it.
// throughput: one input transaction per cycle while full is low; the stack
// keeps its top in a register and prefetches the next entry from the stack
// memory each cycle, so pushes and pops run back to back with one write and one read.
// plain text bytes are dropped at the front and never occupy the op queue.
// stack depth is STACK_DEPTH; an extra push reports overflow and halts.
// reset empties both queues, clears the stack, sets the line count to 1 and
// clears the halt flag; the stack memory itself is not cleared.
// when the receiver stalls, results queue up, then the back stops, then the
// op queue fills and full is raised; nothing is lost.
// ----------------------------------------------------------------------------
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = BBC_STACK_DEPTH,
    parameter int QUEUE_DEPTH = BBC_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire t_item i_data,
    output logic       empty,
    input  wire logic  pop,
    output t_result    o_data
);

    localparam int OP_W  = $bits(t_op);
    localparam int RES_W = $bits(t_result);

    logic    op_push, op_full, op_empty, op_pop;
    t_op     op_in, op_out;
    logic    res_push, res_full;
    t_result res_in;

    bbc_front u_front (
        .i_item    (i_data),
        .i_push    (push),
        .o_full    (full),
        .o_op_push (op_push),
        .o_op      (op_in),
        .i_op_full (op_full)
    );

    bbc_fifo #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (op_out),
        .o_empty (op_empty)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (op_empty),
        .i_op       (op_out),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    bbc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_empty (empty)
    );

endmodule
`default_nettype wire

/* rtl/bbc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_checker
// port-level checks for the bracket balance checker
// ----------------------------------------------------------------------------
module bbc_checker
    import bbc_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    empty,
    input wire logic    pop,
    input wire t_result o_data
);

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data)))
        else $error("pending result changed");

    // only a mismatch names an offending closer
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_data.found_char != 8'h00)) |-> (o_data.status == ST_MISMATCH))
        else $error("found_char set without mismatch");

    // balanced means nothing left on the stack
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_data.status == ST_BALANCED)) |-> (o_data.top_char == 8'h00))
        else $error("balanced with non-empty stack");

    // line count never wraps to zero
    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data.line_number != '0))
        else $error("line number zero");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data)
);
`default_nettype wire

/* test/bracket_balance_checker_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_tb
// feeds directed and random byte streams through the push/full side, predicts
// every report from a behavioral copy of the bracket stack, line count and
// halt flag, and compares each transaction popped from the result side with
// the oldest prediction; both sides idle at random outside one steady stretch
// ----------------------------------------------------------------------------
module bracket_balance_checker_tb;
    import bbc_pkg::*;

    localparam int ITEM_TARGET    = 1350;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    localparam int IDLE_PERCENT   = 14;
    localparam int SW             = $clog2(BBC_STACK_DEPTH);
    localparam logic [BBC_LINE_W-1:0] LINE_FULL = '1;
    localparam logic [7:0] OPENERS [3] = '{CH_BRACE_L, CH_BRACK_L, CH_PAREN_L};
    localparam logic [7:0] CLOSERS [3] = '{CH_BRACE_R, CH_BRACK_R, CH_PAREN_R};

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push    = 1'b0;
    logic    full;
    t_item   i_data  = '0;
    logic    empty;
    logic    pop     = 1'b0;
    t_result o_data;

    t_item   pending_items [$];
    t_result expected_reports [$];
    int      accepted_items = 0;
    int      mismatches     = 0;
    int      idle_cycles    = 0;
    logic    draining       = 1'b0;

    logic [2:0]            nest_stack [BBC_STACK_DEPTH];
    int                    nest_level  = 0;
    logic [BBC_LINE_W-1:0] line_count  = BBC_LINE_W'(1);
    logic                  stopped     = 1'b0;

    always #4 i_clk = ~i_clk;

    bracket_balance_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    function automatic bit steady_stretch();
        return accepted_items >= 500 && accepted_items < 800;
    endfunction

    function automatic logic [7:0] top_bracket();
        logic [2:0] code;
        if (nest_level == 0) return 8'h00;
        code = nest_stack[SW'(nest_level - 1)];
        return (code < CODE_BRACE_R) ? OPENERS[code[1:0]]
                                     : CLOSERS[2'(code - CODE_CLOSE_OFS)];
    endfunction

    task automatic predict_report(input t_item it);
        t_result    rep;
        logic       emit;
        logic       is_bracket;
        logic [2:0] code;
        rep        = '0;
        emit       = 1'b0;
        is_bracket = 1'b1;
        code       = CODE_BRACE_L;
        case (it.char_code)
            CH_BRACE_L: code = CODE_BRACE_L;
            CH_BRACK_L: code = CODE_BRACK_L;
            CH_PAREN_L: code = CODE_PAREN_L;
            CH_BRACE_R: code = CODE_BRACE_R;
            CH_BRACK_R: code = CODE_BRACK_R;
            CH_PAREN_R: code = CODE_PAREN_R;
            default:    is_bracket = 1'b0;
        endcase
        rep.line_number = line_count;
        rep.top_char    = top_bracket();
        if (it.end_of_text) begin
            if (!stopped) begin
                emit = 1'b1;
                if (nest_level == 0) begin
                    rep.status = ST_BALANCED;
                end else if (nest_stack[SW'(nest_level - 1)] <= CODE_PAREN_L) begin
                    rep.status = ST_UNCLOSED;
                end else begin
                    rep.status = ST_STRAY;
                end
            end
            nest_level = 0;
            line_count = BBC_LINE_W'(1);
            stopped    = 1'b0;
        end else if (!stopped && is_bracket) begin
            if (code >= CODE_BRACE_R && nest_level != 0
                    && nest_stack[SW'(nest_level - 1)] == code - CODE_CLOSE_OFS) begin
                nest_level--;
            end else if (code >= CODE_BRACE_R && nest_level != 0) begin
                emit           = 1'b1;
                rep.status     = ST_MISMATCH;
                rep.found_char = it.char_code;
                stopped        = 1'b1;
            end else if (nest_level >= BBC_STACK_DEPTH) begin
                emit       = 1'b1;
                rep.status = ST_OVERFLOW;
                stopped    = 1'b1;
            end else begin
                nest_stack[SW'(nest_level)] = code;
                nest_level++;
            end
        end else if (!stopped && it.char_code == CH_NEWLINE && line_count != LINE_FULL) begin
            line_count++;
        end
        if (emit) expected_reports.push_back(rep);
    endtask

    task automatic check_report(input t_result got);
        t_result want;
        logic    bad;
        want = '0;
        bad  = 1'b1;
        if (expected_reports.size() != 0) begin
            want = expected_reports.pop_front();
            bad  = want.status != got.status || want.line_number != got.line_number
                || want.found_char != got.found_char || want.top_char != got.top_char;
        end
        if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("report error at %0t: expected status %0d line %0d found %h top %h,",
                         $realtime, want.status, want.line_number, want.found_char,
                         want.top_char);
                $display("    got status %0d line %0d found %h top %h%s",
                         got.status, got.line_number, got.found_char, got.top_char,
                         (want == '0) ? " (none expected)" : "");
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_report(i_data);
                void'(pending_items.pop_front());
                accepted_items++;
            end
            if (!(push && full)) begin
                if (pending_items.size() != 0
                        && (steady_stretch() || $urandom_range(99) >= IDLE_PERCENT)) begin
                    push   <= 1'b1;
                    i_data <= pending_items[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_report(o_data);
            pop <= steady_stretch() || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || draining || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic [7:0] ch, input logic eot);
        t_item it;
        it.char_code   = ch;
        it.end_of_text = eot;
        pending_items.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) add_item(s[k], 1'b0);
    endtask

    function automatic logic [7:0] filler_byte();
        logic [7:0] ch;
        if ($urandom_range(99) < 15) return CH_NEWLINE;
        do begin
            ch = 8'($urandom_range(255));
        end while (ch == CH_BRACE_L || ch == CH_BRACK_L || ch == CH_PAREN_L
                   || ch == CH_BRACE_R || ch == CH_BRACK_R || ch == CH_PAREN_R);
        return ch;
    endfunction

    task automatic build_random_text();
        int kind;
        int steps;
        int max_depth;
        int corrupt_at;
        int pick;
        int opens [$];
        kind       = $urandom_range(99);
        steps      = $urandom_range(4, 30);
        max_depth  = $urandom_range(1, 8);
        corrupt_at = (kind >= 75 && kind < 90) ? $urandom_range(0, steps - 1) : -1;
        if (kind < 5) begin
            // deep nesting, sometimes past the stack depth
            max_depth = $urandom_range(BBC_STACK_DEPTH - 4, BBC_STACK_DEPTH + 2);
            for (int k = 0; k < max_depth; k++) begin
                pick = $urandom_range(2);
                opens.push_back(pick);
                add_item(OPENERS[2'(pick)], 1'b0);
                if ($urandom_range(9) == 0) add_item(filler_byte(), 1'b0);
            end
        end else if (kind >= 90) begin
            for (int k = 0; k < steps; k++) add_item(8'($urandom_range(255)), 1'b0);
        end else begin
            for (int k = 0; k < steps; k++) begin
                pick = $urandom_range(99);
                if (k == corrupt_at) begin
                    add_item(($urandom_range(1) != 0) ? OPENERS[2'($urandom_range(2))]
                                                      : CLOSERS[2'($urandom_range(2))],
                             1'b0);
                end else if (opens.size() != 0 && (pick < 35 || opens.size() >= max_depth)) begin
                    add_item(CLOSERS[2'(opens.pop_back())], 1'b0);
                end else if (pick < 70) begin
                    pick = $urandom_range(2);
                    opens.push_back(pick);
                    add_item(OPENERS[2'(pick)], 1'b0);
                end else begin
                    add_item(filler_byte(), 1'b0);
                end
            end
        end
        if (kind < 90 && $urandom_range(9) != 0) begin
            while (opens.size() != 0) begin
                add_item(CLOSERS[2'(opens.pop_back())], 1'b0);
                if ($urandom_range(7) == 0) add_item(filler_byte(), 1'b0);
            end
        end
        add_item(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        add_text("()");
        add_item(8'h00, 1'b1);
        add_text("{\n[\n(");
        add_item(8'hFF, 1'b1);
        add_text(")");
        add_item(8'h5A, 1'b1);
        add_text("])\n(");
        add_item(8'h00, 1'b1);
        add_text("{)");
        add_item(8'hA5, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_text("}");
        add_item(8'h7F, 1'b1);
        // stack overflow, then bytes while halted
        for (int k = 0; k <= BBC_STACK_DEPTH; k++) add_item(CH_BRACK_L, 1'b0);
        add_text(")\n");
        add_item(8'h01, 1'b1);
        while (pending_items.size() < ITEM_TARGET) build_random_text();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() != 0 || push) @(posedge i_clk);
        while (expected_reports.size() != 0) @(posedge i_clk);
        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bbc_pkg.sv
rtl/bbc_fifo.sv
rtl/bbc_front.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker.sv
rtl/bbc_checker.sv
test/bracket_balance_checker_tb.sv
